// ===== rtl/assert_macros.svh =====
// Assertion macros for the kanji converter result queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define KCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define KCC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/kcc_pkg.sv =====
// Types, codes and pair conversion functions of the kanji code converter
package kcc_pkg;

  typedef enum logic [1:0] {
    MODE_SJIS_TO_JIS  = 2'd0,
    MODE_JIS_TO_SJIS  = 2'd1,
    MODE_SJIS_TO_TRON = 2'd2,
    MODE_TRON_TO_SJIS = 2'd3
  } kcc_mode_t;

  localparam int unsigned AddrW = 3;
  localparam logic REG_MODE_IDX = 1'b0;

  // result queue entries; keep a power of two
  localparam int unsigned QueueDepth = 4;

  localparam logic [15:0] SJIS_SPACE = 16'h8520;
  localparam logic [15:0] JIS_SPACE  = 16'h2121;
  localparam logic [15:0] SJIS_IDEO_SPACE = 16'h8140;

  typedef struct packed {
    kcc_mode_t mode;
    logic      clear;
  } kcc_cfg_t;

  typedef struct packed {
    logic [1:0] count;
    logic [7:0] first;
    logic [7:0] second;
  } kcc_res_t;

  function automatic logic [15:0] sjis_to_jis(input logic [15:0] code);
    logic [15:0] hi;
    logic [15:0] lo;
    logic [15:0] res;
    hi = {8'h00, code[15:8]};
    lo = {8'h00, code[7:0]};
    res = code;
    if (code == SJIS_SPACE) begin
      res = JIS_SPACE;
    end else if (code[15:8] == 8'h80 || code[15:8] >= 8'hf0) begin
      res = code;
    end else begin
      if (code[15:8] < 8'ha0) begin
        hi = hi - 16'h0070;
      end else begin
        hi = hi - 16'h00b0;
      end
      if (lo >= 16'h0080) begin
        lo = lo - 16'h0001;
      end
      hi = {hi[14:0], 1'b0};
      if (lo >= 16'h009e) begin
        lo = lo - 16'h005e;
      end else begin
        hi = hi - 16'h0001;
      end
      lo = lo - 16'h001f;
      if (hi == 16'h002a) begin
        res = lo | 16'h0080;
      end else if (hi == 16'h0029) begin
        res = {8'h00, lo[7:0]};
      end else begin
        res = {hi[7:0], lo[7:0]};
      end
    end
    return res;
  endfunction

  function automatic logic [15:0] jis_to_sjis(input logic [15:0] code);
    logic [8:0]  lo;
    logic [7:0]  hi;
    logic [15:0] res;
    lo = {1'b0, code[7:0]} + 9'h01f;
    hi = {1'b0, code[15:9]};
    if (!code[8]) begin
      hi = hi - 8'h01;
      lo = lo + 9'h05e;
    end
    if (lo >= 9'h07f) begin
      lo = lo + 9'h001;
    end
    if (hi < 8'h2f) begin
      hi = hi + 8'h71;
    end else begin
      hi = hi + 8'hb1;
    end
    if (code == JIS_SPACE) begin
      res = SJIS_IDEO_SPACE;
    end else begin
      res = {hi, lo[7:0]};
    end
    return res;
  endfunction

endpackage

// ===== rtl/kanji_code_stream_converter.sv =====
// Top level of the byte-stream kanji code converter
// A result byte is written into the result queue when the item that completes it is accepted.
// Throughput: one input item per cycle; a pair gives two bytes over two items.
// Input stalls only while the result queue has fewer than two free entries.
// Reset: synchronous, active high; mode returns to Shift-JIS to JIS, no lead held,
// result queue empty.
module kanji_code_stream_converter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] in_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // [7:0] out_byte
  output logic                      m_tlast,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kcc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  kcc_pkg::kcc_cfg_t cfg;
  kcc_pkg::kcc_res_t res;
  logic              room;
  logic              accept;

  assign s_tready = room;
  assign accept   = s_tvalid && room;

  kcc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kcc_pair_conv u_conv (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .in_byte (s_tdata),
    .res     (res)
  );

  kcc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .res       (res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ===== rtl/kcc_cfg_regs.sv =====
// Configuration register file with its bus port
module kcc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kcc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output kcc_pkg::kcc_cfg_t         cfg
);

  kcc_pkg::kcc_mode_t mode;
  logic               wr_mode;

  assign pready  = 1'b1;
  assign wr_mode = psel && penable && pwrite && (paddr[2] == kcc_pkg::REG_MODE_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= kcc_pkg::MODE_SJIS_TO_JIS;
    end else if (wr_mode) begin
      mode <= kcc_pkg::kcc_mode_t'(pwdata[1:0]);
    end
  end

  always_comb begin
    if (paddr[2] == kcc_pkg::REG_MODE_IDX) begin
      prdata = {30'd0, mode};
    end else begin
      prdata = 32'd0;
    end
  end

  assign cfg.mode  = mode;
  assign cfg.clear = wr_mode;

endmodule

// ===== rtl/kcc_pair_conv.sv =====
// Lead byte holding and pair conversion into zero, one or two result bytes
module kcc_pair_conv (
  input  logic              clk,
  input  logic              rst,
  input  kcc_pkg::kcc_cfg_t cfg,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  output kcc_pkg::kcc_res_t res
);

  logic        lead_pending;
  logic [7:0]  held_lead_byte;
  logic        sjis_src;
  logic [15:0] conv;

  assign sjis_src = (cfg.mode == kcc_pkg::MODE_SJIS_TO_JIS) ||
                    (cfg.mode == kcc_pkg::MODE_SJIS_TO_TRON);

  always_comb begin
    conv = 16'd0;
    res  = '0;
    if (!lead_pending) begin
      if (sjis_src && !in_byte[7]) begin
        res.count = 2'd1;
        res.first = in_byte;
      end
    end else begin
      res.count = 2'd2;
      unique case (cfg.mode)
        kcc_pkg::MODE_SJIS_TO_JIS: begin
          conv       = kcc_pkg::sjis_to_jis({held_lead_byte, in_byte});
          res.first  = conv[15:8];
          res.second = conv[7:0];
        end
        kcc_pkg::MODE_JIS_TO_SJIS: begin
          conv       = kcc_pkg::jis_to_sjis({held_lead_byte, in_byte});
          res.first  = conv[15:8];
          res.second = conv[7:0];
        end
        kcc_pkg::MODE_SJIS_TO_TRON: begin
          conv       = kcc_pkg::sjis_to_jis({held_lead_byte, in_byte});
          res.first  = conv[7:0];
          res.second = conv[15:8];
        end
        default: begin
          conv       = kcc_pkg::jis_to_sjis({in_byte, held_lead_byte});
          res.first  = conv[15:8];
          res.second = conv[7:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      lead_pending   <= 1'b0;
      held_lead_byte <= 8'd0;
    end else if (accept) begin
      if (lead_pending) begin
        lead_pending   <= 1'b0;
        held_lead_byte <= 8'd0;
      end else if (!(sjis_src && !in_byte[7])) begin
        lead_pending   <= 1'b1;
        held_lead_byte <= in_byte;
      end
    end
  end

endmodule

// ===== rtl/kcc_out_queue.sv =====
// Result queue taking up to two bytes per cycle while it has room and giving one per cycle while out_ready is high
`include "assert_macros.svh"

module kcc_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kcc_pkg::kcc_res_t res,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  localparam int unsigned Depth = kcc_pkg::QueueDepth;
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [8:0]      entries [Depth];
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW-1:0] wr_ptr;
  logic [CntW-1:0] count;
  logic [1:0]      push_n;
  logic            pop;

  assign push_n    = push ? res.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign room      = count <= CntW'(Depth - 2);
  assign out_valid = count != '0;
  assign out_byte  = entries[rd_ptr][7:0];
  assign out_last  = entries[rd_ptr][8];

  always_ff @(posedge clk) begin
    if (push_n == 2'd1) begin
      entries[wr_ptr] <= {1'b1, res.first};
    end else if (push_n == 2'd2) begin
      entries[wr_ptr]               <= {1'b0, res.first};
      entries[wr_ptr + PtrW'(1)]    <= {1'b1, res.second};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_n);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count + CntW'(push_n) - CntW'(pop);
    end
  end

  `KCC_ASSERT(count_bound, count <= CntW'(Depth), "queue count beyond depth")
  `KCC_ASSERT(push_fits, (push_n != 2'd0) |-> room, "push into a full queue")
  `KCC_ASSERT(count_track, (push_n == 2'd0 && !pop) |=> $stable(count), "queue count drifted")
  `KCC_ASSERT_RST(reset_empty, rst |=> (count == '0), "queue not empty after reset")

endmodule
